/* rtl/nfps_pkg.sv */
`timescale 1ns / 1ps

package nfps_pkg;

	// Array geometry
	localparam int PAGE_WORDS  = 256;
	localparam int NUM_PAGES   = 8;
	localparam int TOTAL_WORDS = PAGE_WORDS * NUM_PAGES;
	localparam int IDX_W       = $clog2(TOTAL_WORDS);
	localparam int WORD_W      = 64;
	localparam int SPAN_BYTES  = TOTAL_WORDS * 8;

	// Function codes
	localparam logic [2:0] FN_ERASE_PAGE = 3'd0;
	localparam logic [2:0] FN_PROGRAM    = 3'd1;
	localparam logic [2:0] FN_READ       = 3'd2;
	localparam logic [2:0] FN_QUERY      = 3'd3;
	localparam logic [2:0] FN_ERASE_ALL  = 3'd4;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_OOB     = 2'd2;

	// Configuration registers
	localparam int         CFG_IDX_W       = 1;
	localparam int         CFG_DATA_W      = 32;
	localparam logic [0:0] REG_WINDOW_BASE = 1'd0;
	localparam logic [0:0] REG_FIRST_PAGE  = 1'd1;
	localparam logic [31:0] WINDOW_BASE_RST = 32'd134463488;
	localparam logic [7:0]  FIRST_PAGE_RST  = 8'd120;

	localparam logic [WORD_W-1:0] ERASED_WORD = {WORD_W{1'b1}};

	typedef struct packed {
		logic [2:0]        func;
		logic [31:0]       byte_address;
		logic [7:0]        page_number;
		logic [WORD_W-1:0] write_data;
		logic [7:0]        byte_enable;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [WORD_W-1:0] read_data;
		logic              page_erased;
	} out_item_t;

	typedef struct packed {
		logic [31:0] window_base;
		logic [7:0]  first_page;
	} cfg_t;

	// Memory request from the sequencer
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [WORD_W-1:0] wdata;
		logic              re;
		logic [IDX_W-1:0]  raddr;
	} ram_req_t;

endpackage

/* rtl/nfps_ram.sv */
`timescale 1ns / 1ps

module nfps_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port; rdata holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/nfps_seq.sv */
`timescale 1ns / 1ps

module nfps_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  nfps_pkg::cfg_t             cfg,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  nfps_pkg::in_item_t         in_item,
	output logic                       out_valid,
	input  logic                       out_ready,
	output nfps_pkg::out_item_t        out_item,
	output nfps_pkg::ram_req_t         ram_req,
	input  logic [nfps_pkg::WORD_W-1:0] ram_rdata
);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_ACCESS, S_WIPE, S_SCAN, S_SCAN_END, S_DONE
	} state_t;

	typedef enum logic [1:0] {K_NONE, K_PROG, K_READ} kind_t;

	state_t                            state_q;
	kind_t                             kind_s1;
	logic [1:0]                        status_s1;
	logic [nfps_pkg::IDX_W-1:0]        idx_s1;
	logic [nfps_pkg::WORD_W-1:0]       wdata_s1;
	logic [nfps_pkg::WORD_W-1:0]       mask_s1;
	logic [nfps_pkg::IDX_W-1:0]        cnt_q;
	logic [nfps_pkg::IDX_W-1:0]        end_q;
	logic                              erased_q;
	logic                              scan_v_s1;
	logic                              out_valid_q;
	nfps_pkg::out_item_t               out_item_q;

	logic                              accept;
	logic                              out_free;
	logic                              out_load;
	logic [32:0]                       addr_x;
	logic [32:0]                       base_x;
	logic [32:0]                       last_x;
	logic [32:0]                       diff_x;
	logic                              below;
	logic                              prog_oob;
	logic                              read_oob;
	logic                              misalign;
	logic [nfps_pkg::IDX_W-1:0]        word_idx;
	logic [7:0]                        page_off;
	logic                              page_ok;
	logic [nfps_pkg::IDX_W-1:0]        page_start;
	logic [nfps_pkg::IDX_W-1:0]        page_end;
	logic [nfps_pkg::WORD_W-1:0]       lane_mask;

	logic [1:0]                        dec_status;
	kind_t                             dec_kind;
	state_t                            dec_next;
	logic [nfps_pkg::IDX_W-1:0]        dec_start;
	logic [nfps_pkg::IDX_W-1:0]        dec_end;
	logic                              dec_erased;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = out_free && (state_q == S_ACCESS || state_q == S_DONE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Window checks, carried out in 33 bits so the top of the window cannot wrap
	assign addr_x   = {1'b0, in_item.byte_address};
	assign base_x   = {1'b0, cfg.window_base};
	assign last_x   = base_x + 33'(nfps_pkg::SPAN_BYTES - 1);
	assign diff_x   = addr_x - base_x;
	assign below    = addr_x < base_x;
	assign prog_oob = below || ((addr_x + 33'd7) > last_x);
	assign read_oob = below || (addr_x > last_x);
	assign misalign = (in_item.byte_address[2:0] != 3'd0);
	assign word_idx = diff_x[nfps_pkg::IDX_W+2:3];

	// Page slot inside the window
	assign page_off   = in_item.page_number - cfg.first_page;
	assign page_ok    = (in_item.page_number >= cfg.first_page) &&
	                    (page_off < 8'(nfps_pkg::NUM_PAGES));
	assign page_start = nfps_pkg::IDX_W'(int'(page_off) * nfps_pkg::PAGE_WORDS);
	assign page_end   = page_start + nfps_pkg::IDX_W'(nfps_pkg::PAGE_WORDS - 1);

	// Byte enables to a bit mask
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			lane_mask[8*b +: 8] = {8{in_item.byte_enable[b]}};
		end
	end

	// Item decode
	always_comb begin
		dec_status = nfps_pkg::ST_OK;
		dec_kind   = K_NONE;
		dec_next   = S_ACCESS;
		dec_start  = '0;
		dec_end    = '0;
		dec_erased = 1'b0;
		case (in_item.func)
			nfps_pkg::FN_ERASE_PAGE: begin
				if (page_ok) begin
					dec_next  = S_WIPE;
					dec_start = page_start;
					dec_end   = page_end;
				end else begin
					dec_status = nfps_pkg::ST_INVALID;
				end
			end
			nfps_pkg::FN_PROGRAM: begin
				if (prog_oob) begin
					dec_status = nfps_pkg::ST_OOB;
				end else if (misalign) begin
					dec_status = nfps_pkg::ST_INVALID;
				end else begin
					dec_kind = K_PROG;
				end
			end
			nfps_pkg::FN_READ: begin
				if (read_oob) begin
					dec_status = nfps_pkg::ST_OOB;
				end else begin
					dec_kind = K_READ;
				end
			end
			nfps_pkg::FN_QUERY: begin
				if (page_ok) begin
					dec_next   = S_SCAN;
					dec_start  = page_start;
					dec_end    = page_end;
					dec_erased = 1'b1;
				end
			end
			nfps_pkg::FN_ERASE_ALL: begin
				dec_next  = S_WIPE;
				dec_start = '0;
				dec_end   = nfps_pkg::IDX_W'(nfps_pkg::TOTAL_WORDS - 1);
			end
			default: begin
				dec_status = nfps_pkg::ST_INVALID;
			end
		endcase
	end

	// Memory port requests
	always_comb begin
		ram_req.re    = (state_q == S_IDLE && accept) || (state_q == S_SCAN);
		ram_req.raddr = (state_q == S_SCAN) ? cnt_q : word_idx;
		ram_req.we    = (state_q == S_CLEAR) || (state_q == S_WIPE) ||
		                (state_q == S_ACCESS && out_free && kind_s1 == K_PROG);
		ram_req.waddr = (state_q == S_ACCESS) ? idx_s1 : cnt_q;
		ram_req.wdata = (state_q == S_ACCESS) ? (ram_rdata & (wdata_s1 | ~mask_s1))
		                                      : nfps_pkg::ERASED_WORD;
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			kind_s1     <= K_NONE;
			status_s1   <= nfps_pkg::ST_OK;
			idx_s1      <= '0;
			wdata_s1    <= '0;
			mask_s1     <= '0;
			cnt_q       <= '0;
			end_q       <= '0;
			erased_q    <= 1'b0;
			scan_v_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			out_item_q  <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == nfps_pkg::IDX_W'(nfps_pkg::TOTAL_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						kind_s1   <= dec_kind;
						status_s1 <= dec_status;
						idx_s1    <= word_idx;
						wdata_s1  <= in_item.write_data;
						mask_s1   <= lane_mask;
						cnt_q     <= dec_start;
						end_q     <= dec_end;
						erased_q  <= dec_erased;
						scan_v_s1 <= 1'b0;
						state_q   <= dec_next;
					end
				end
				S_ACCESS: begin
					if (out_free) begin
						out_item_q.status      <= status_s1;
						out_item_q.read_data   <= (kind_s1 == K_READ) ? ram_rdata : '0;
						out_item_q.page_erased <= 1'b0;
						state_q                <= S_IDLE;
					end
				end
				S_WIPE: begin
					if (cnt_q == end_q) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SCAN: begin
					scan_v_s1 <= 1'b1;
					if (scan_v_s1 && ram_rdata != nfps_pkg::ERASED_WORD) begin
						erased_q <= 1'b0;
					end
					if (cnt_q == end_q) begin
						state_q <= S_SCAN_END;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SCAN_END: begin
					if (ram_rdata != nfps_pkg::ERASED_WORD) begin
						erased_q <= 1'b0;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_item_q.status      <= status_s1;
						out_item_q.read_data   <= '0;
						out_item_q.page_erased <= erased_q;
						state_q                <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A program write only ever clears bits of the stored word
	a_prog_clears_only: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_req.we && state_q == S_ACCESS) |-> ((ram_req.wdata & ~ram_rdata) == '0))
		else $error("program write sets bits");

	// Writes from an access only for an accepted program
	a_prog_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_req.we && state_q == S_ACCESS) |-> (status_s1 == nfps_pkg::ST_OK))
		else $error("write for a rejected item");

	// Sweep counter never passes its end index
	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WIPE || state_q == S_SCAN) |-> (cnt_q <= end_q))
		else $error("sweep counter out of range");

	// The last scan read is always checked
	a_scan_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN_END) |-> scan_v_s1)
		else $error("scan ended without a pending read");

	// A result is loaded only into a free output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> ($stable(out_item_q) && out_valid_q))
		else $error("pending result overwritten");

endmodule

/* rtl/nor_flash_page_store.sv */
`timescale 1ns / 1ps

// NOR flash page store: a window of NUM_PAGES pages of PAGE_WORDS 64-bit words.
// Input channel (in_valid/in_ready/in_item) takes one access item: erase page,
// program word (bits can only be cleared), read word, query page erased or
// erase all. Output channel (out_valid/out_ready/out_item) returns exactly one
// result item per input item, in order. The configuration port writes
// window_base (index 0) or first_page (index 1) on any cycle with cfg_we high.
// Read, program and rejected items: the word is read from memory, then the
// program write-back and the result load happen together. Erase page and erase
// all write their words in turn, then load the result; query page reads its
// words, checks the last read, then loads the result. in_ready is low from
// acceptance until the result is loaded, so the next item waits for that.
// Erases and queries walk the page (erase all: the whole array) through the
// word-wide memory, one word per cycle; one item is in progress at a time.
// After reset the whole array is cleared to all ones, all TOTAL_WORDS words
// (2048 by default), with in_ready low; configuration writes are taken.
// The result waits in an output register; if the receiver stalls, the block
// still takes one more item, runs it, then holds it with in_ready low until the
// register frees.
module nor_flash_page_store (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  nfps_pkg::in_item_t               in_item,
	output logic                             out_valid,
	input  logic                             out_ready,
	output nfps_pkg::out_item_t              out_item,
	input  logic                             cfg_we,
	input  logic [nfps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nfps_pkg::CFG_DATA_W-1:0]  cfg_data
);

	nfps_pkg::cfg_t                 cfg_q;
	nfps_pkg::ram_req_t             ram_req;
	logic [nfps_pkg::WORD_W-1:0]    ram_rdata;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_base <= nfps_pkg::WINDOW_BASE_RST;
			cfg_q.first_page  <= nfps_pkg::FIRST_PAGE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				nfps_pkg::REG_WINDOW_BASE: cfg_q.window_base <= cfg_data;
				nfps_pkg::REG_FIRST_PAGE:  cfg_q.first_page  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	nfps_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	nfps_ram #(
		.DEPTH (nfps_pkg::TOTAL_WORDS),
		.WIDTH (nfps_pkg::WORD_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

endmodule

/* sim/tb_nor_flash_page_store.sv */
`timescale 1ns / 1ps

module tb_nor_flash_page_store;

	// Clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #4 clk = ~clk;

	// Block ports, all at known values from time zero
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	nfps_pkg::in_item_t              in_item = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	nfps_pkg::out_item_t             out_item;
	logic                            cfg_we = 1'b0;
	logic [nfps_pkg::CFG_IDX_W-1:0]  cfg_index = nfps_pkg::REG_WINDOW_BASE;
	logic [nfps_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	nor_flash_page_store u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the array and its window registers
	logic [nfps_pkg::WORD_W-1:0] flash_shadow [nfps_pkg::TOTAL_WORDS];
	logic [31:0]                 win_base;
	logic [7:0]                  first_pg;

	// Replies the shadow array says the block owes, oldest first
	nfps_pkg::out_item_t flash_replies [$];

	bit calm = 1'b0;
	int stall_left = 0;
	int err_count = 0;
	int items_sent = 0;
	int settings_run = 0;
	int status_seen [3] = '{0, 0, 0};
	int blank_pages_seen = 0;

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic nfps_pkg::in_item_t flash_cmd(input logic [2:0] f,
			input logic [31:0] a, input logic [7:0] p, input logic [63:0] d,
			input logic [7:0] be);
		nfps_pkg::in_item_t it;
		it.func         = f;
		it.byte_address = a;
		it.page_number  = p;
		it.write_data   = d;
		it.byte_enable  = be;
		return it;
	endfunction

	// Window slot of a physical page, -1 when outside the window
	function automatic int page_slot(input logic [7:0] p);
		if (int'(p) < int'(first_pg))
			return -1;
		if (int'(p) - int'(first_pg) >= nfps_pkg::NUM_PAGES)
			return -1;
		return int'(p) - int'(first_pg);
	endfunction

	// Apply one access to the shadow array and work out the block's reply
	task automatic flash_access(input nfps_pkg::in_item_t it,
			output nfps_pkg::out_item_t res);
		logic [32:0]                 base_x, last_x, addr_x;
		logic [nfps_pkg::WORD_W-1:0] lanes;
		int                          slot;
		int                          idx;
		int                          w;
		res = '0;
		res.status = nfps_pkg::ST_OK;
		base_x = {1'b0, win_base};
		last_x = base_x + 33'(nfps_pkg::SPAN_BYTES - 1);
		addr_x = {1'b0, it.byte_address};
		slot = page_slot(it.page_number);
		case (it.func)
			nfps_pkg::FN_ERASE_PAGE: begin
				if (slot < 0)
					res.status = nfps_pkg::ST_INVALID;
				else
					for (w = 0; w < nfps_pkg::PAGE_WORDS; w++)
						flash_shadow[slot * nfps_pkg::PAGE_WORDS + w] =
							nfps_pkg::ERASED_WORD;
			end
			nfps_pkg::FN_PROGRAM: begin
				if (addr_x < base_x || addr_x + 33'd7 > last_x) begin
					res.status = nfps_pkg::ST_OOB;
				end else if (it.byte_address[2:0] != 3'd0) begin
					res.status = nfps_pkg::ST_INVALID;
				end else begin
					idx = int'((addr_x - base_x) >> 3);
					lanes = '0;
					for (w = 0; w < 8; w++)
						if (it.byte_enable[w])
							lanes[8*w +: 8] = 8'hFF;
					flash_shadow[idx] = flash_shadow[idx] & (it.write_data | ~lanes);
				end
			end
			nfps_pkg::FN_READ: begin
				if (addr_x < base_x || addr_x > last_x) begin
					res.status = nfps_pkg::ST_OOB;
				end else begin
					idx = int'((addr_x - base_x) >> 3);
					res.read_data = flash_shadow[idx];
				end
			end
			nfps_pkg::FN_QUERY: begin
				if (slot >= 0) begin
					res.page_erased = 1'b1;
					for (w = 0; w < nfps_pkg::PAGE_WORDS; w++)
						if (flash_shadow[slot * nfps_pkg::PAGE_WORDS + w] !=
								nfps_pkg::ERASED_WORD)
							res.page_erased = 1'b0;
				end
			end
			nfps_pkg::FN_ERASE_ALL: begin
				for (w = 0; w < nfps_pkg::TOTAL_WORDS; w++)
					flash_shadow[w] = nfps_pkg::ERASED_WORD;
			end
			default: res.status = nfps_pkg::ST_INVALID;
		endcase
	endtask

	// Sender side: drop valid and idle; n sets the length of the pause
	task automatic sender_idle(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Offer one item, hold it until taken, then record the reply it owes
	task automatic send_access(input nfps_pkg::in_item_t it);
		nfps_pkg::out_item_t res;
		if (!calm && $urandom_range(0, 7) == 0)
			sender_idle($urandom_range(1, 11));
		in_valid <= 1'b1;
		in_item  <= it;
		do
			@(posedge clk);
		while (!in_ready);
		flash_access(it, res);
		flash_replies.push_back(res);
		items_sent++;
	endtask

	// Stop sending and let every owed reply come back
	task automatic wait_flash_idle();
		in_valid <= 1'b0;
		while (flash_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Both window registers, back to back
	task automatic set_window(input logic [31:0] base, input logic [7:0] page);
		cfg_we    <= 1'b1;
		cfg_index <= nfps_pkg::REG_WINDOW_BASE;
		cfg_data  <= base;
		@(posedge clk);
		cfg_index <= nfps_pkg::REG_FIRST_PAGE;
		cfg_data  <= nfps_pkg::CFG_DATA_W'(page);
		@(posedge clk);
		cfg_we <= 1'b0;
		win_base = base;
		first_pg = page;
		settings_run++;
	endtask

	// Boundaries of the current window and page range
	task automatic probe_window_edges();
		logic [31:0] last_byte;
		last_byte = win_base + 32'(nfps_pkg::SPAN_BYTES - 1);
		send_access(flash_cmd(nfps_pkg::FN_READ, win_base, 8'($urandom), rnd64(),
			8'($urandom)));
		send_access(flash_cmd(nfps_pkg::FN_READ, last_byte, 8'($urandom), rnd64(),
			8'($urandom)));
		send_access(flash_cmd(nfps_pkg::FN_READ, win_base - 32'd1, 8'($urandom), rnd64(),
			8'hFF));
		send_access(flash_cmd(nfps_pkg::FN_READ, last_byte + 32'd1, 8'($urandom), rnd64(),
			8'hFF));
		send_access(flash_cmd(nfps_pkg::FN_PROGRAM, last_byte - 32'd7, 8'($urandom),
			rnd64(), 8'($urandom)));
		send_access(flash_cmd(nfps_pkg::FN_PROGRAM, last_byte - 32'd6, 8'($urandom),
			rnd64(), 8'hFF));
		send_access(flash_cmd(nfps_pkg::FN_PROGRAM, win_base, 8'($urandom), rnd64(),
			8'hFF));
		send_access(flash_cmd(nfps_pkg::FN_QUERY, 32'($urandom), first_pg, rnd64(),
			8'($urandom)));
		send_access(flash_cmd(nfps_pkg::FN_QUERY, 32'($urandom),
			first_pg + 8'(nfps_pkg::NUM_PAGES - 1), rnd64(), 8'($urandom)));
		send_access(flash_cmd(nfps_pkg::FN_QUERY, 32'($urandom), first_pg - 8'd1, rnd64(),
			8'hFF));
		send_access(flash_cmd(nfps_pkg::FN_QUERY, 32'($urandom),
			first_pg + 8'(nfps_pkg::NUM_PAGES), rnd64(), 8'hFF));
		send_access(flash_cmd(nfps_pkg::FN_ERASE_PAGE, 32'($urandom),
			first_pg + 8'(nfps_pkg::NUM_PAGES), rnd64(), 8'($urandom)));
	endtask

	// One random access or short sequence, mostly well formed
	task automatic random_access();
		logic [31:0] a;
		logic [7:0]  p;
		int          pick;
		pick = $urandom_range(0, 99);
		a = win_base + 32'($urandom_range(0, nfps_pkg::TOTAL_WORDS - 1)) * 32'd8;
		p = first_pg + 8'($urandom_range(0, nfps_pkg::NUM_PAGES - 1));
		if (pick < 30) begin
			// program an aligned word with random lanes
			a = (a + 32'd7) & ~32'd7;
			send_access(flash_cmd(nfps_pkg::FN_PROGRAM, a, 8'($urandom), rnd64(),
				($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom)));
		end else if (pick < 55) begin
			send_access(flash_cmd(nfps_pkg::FN_READ, a + 32'($urandom_range(0, 7)),
				8'($urandom), rnd64(), 8'($urandom)));
		end else if (pick < 70) begin
			// program, then read the same word back
			a = (a + 32'd7) & ~32'd7;
			send_access(flash_cmd(nfps_pkg::FN_PROGRAM, a, 8'($urandom), rnd64(),
				8'($urandom)));
			send_access(flash_cmd(nfps_pkg::FN_READ, a + 32'($urandom_range(0, 7)),
				8'($urandom), rnd64(), 8'($urandom)));
		end else if (pick < 77) begin
			// erase a page and ask whether it is blank
			send_access(flash_cmd(nfps_pkg::FN_ERASE_PAGE, 32'($urandom), p, rnd64(),
				8'($urandom)));
			send_access(flash_cmd(nfps_pkg::FN_QUERY, 32'($urandom), p, rnd64(),
				8'($urandom)));
		end else if (pick < 85) begin
			p = first_pg + 8'($urandom_range(0, nfps_pkg::NUM_PAGES + 1)) - 8'd1;
			send_access(flash_cmd(nfps_pkg::FN_QUERY, 32'($urandom), p, rnd64(),
				8'($urandom)));
		end else if (pick < 87) begin
			send_access(flash_cmd(nfps_pkg::FN_ERASE_PAGE, 32'($urandom), 8'($urandom),
				rnd64(), 8'($urandom)));
		end else if (pick < 88) begin
			send_access(flash_cmd(nfps_pkg::FN_ERASE_ALL, 32'($urandom), 8'($urandom),
				rnd64(), 8'($urandom)));
		end else begin
			// noise: any code, any address, any page
			send_access(flash_cmd(3'($urandom), 32'($urandom), 8'($urandom), rnd64(),
				8'($urandom)));
		end
	endtask

	// Default window: boundaries, lane handling, bad codes, erases
	task automatic test_directed();
		int f;
		probe_window_edges();
		send_access(flash_cmd(nfps_pkg::FN_PROGRAM, win_base + 32'd8, 8'd0, 64'd0, 8'hFF));
		send_access(flash_cmd(nfps_pkg::FN_READ, win_base + 32'd8, 8'd0, 64'd0, 8'h00));
		send_access(flash_cmd(nfps_pkg::FN_PROGRAM, win_base + 32'd16, 8'hFF, 64'd0,
			8'h00));
		send_access(flash_cmd(nfps_pkg::FN_READ, win_base + 32'd21, 8'hFF, 64'd0, 8'h00));
		send_access(flash_cmd(nfps_pkg::FN_PROGRAM, win_base + 32'd24, 8'd0, rnd64(),
			8'hA5));
		send_access(flash_cmd(nfps_pkg::FN_READ, win_base + 32'd31, 8'd0, rnd64(), 8'h5A));
		send_access(flash_cmd(nfps_pkg::FN_PROGRAM, win_base + 32'd3, 8'd0, 64'd0, 8'hFF));
		for (f = int'(nfps_pkg::FN_ERASE_ALL) + 1; f < 8; f++)
			send_access(flash_cmd(3'(f), 32'hFFFF_FFFF, 8'hFF, {nfps_pkg::WORD_W{1'b1}},
				8'hFF));
		send_access(flash_cmd(nfps_pkg::FN_READ, 32'hFFFF_FFFF, 8'hFF, 64'd0, 8'hFF));
		send_access(flash_cmd(nfps_pkg::FN_READ, 32'd0, 8'd0, 64'd0, 8'd0));
		send_access(flash_cmd(nfps_pkg::FN_ERASE_PAGE, 32'd0, 8'hFF, 64'd0, 8'd0));
		send_access(flash_cmd(nfps_pkg::FN_ERASE_PAGE, 32'd0, first_pg, 64'd0, 8'd0));
		send_access(flash_cmd(nfps_pkg::FN_QUERY, 32'd0, first_pg, 64'd0, 8'd0));
		send_access(flash_cmd(nfps_pkg::FN_ERASE_ALL, 32'd0, 8'd0, 64'd0, 8'd0));
		send_access(flash_cmd(nfps_pkg::FN_QUERY, 32'd0, first_pg + 8'd1, 64'd0, 8'd0));
		wait_flash_idle();
	endtask

	// Several windows, extremes included, each probed then exercised
	task automatic test_window_settings();
		logic [31:0] bases [4];
		logic [7:0]  pages [4];
		int          s;
		int          n;
		bases = '{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF - 32'(nfps_pkg::SPAN_BYTES - 1),
			32'h1234_5673};
		pages = '{8'd0, 8'd255, 8'd248, 8'd77};
		for (s = 0; s < 4; s++) begin
			set_window(bases[s], pages[s]);
			probe_window_edges();
			for (n = 0; n < 30; n++)
				random_access();
			wait_flash_idle();
		end
	endtask

	// Bulk random traffic at the reset window; a full drain after 200 items,
	// no idling on either side towards the end
	task automatic test_random_traffic();
		int start;
		bit drained;
		set_window(nfps_pkg::WINDOW_BASE_RST, nfps_pkg::FIRST_PAGE_RST);
		start = items_sent;
		drained = 1'b0;
		while (items_sent - start < 450) begin
			if (!drained && items_sent - start >= 200) begin
				wait_flash_idle();
				drained = 1'b1;
			end
			if (items_sent - start >= 350)
				calm = 1'b1;
			random_access();
		end
		wait_flash_idle();
	endtask

	// Receiver side: random stall bursts until the calm stretch
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= (stall_left == 1);
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(1, 11);
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Compare every reply taken with the oldest one owed
	always @(posedge clk) begin : reply_check
		nfps_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (flash_replies.size() == 0) begin
				$error("unexpected reply: status %0d read_data %h", out_item.status,
					out_item.read_data);
				err_count++;
			end else begin
				want = flash_replies.pop_front();
				if (out_item.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, out_item.status);
					err_count++;
				end
				if (out_item.read_data !== want.read_data) begin
					$error("read_data: expected %h, actual %h", want.read_data,
						out_item.read_data);
					err_count++;
				end
				if (out_item.page_erased !== want.page_erased) begin
					$error("page_erased: expected %0b, actual %0b", want.page_erased,
						out_item.page_erased);
					err_count++;
				end
				if (want.status <= nfps_pkg::ST_OOB)
					status_seen[want.status]++;
				if (want.page_erased)
					blank_pages_seen++;
			end
		end
	end

	initial begin
		for (int w = 0; w < nfps_pkg::TOTAL_WORDS; w++)
			flash_shadow[w] = nfps_pkg::ERASED_WORD;
		win_base = nfps_pkg::WINDOW_BASE_RST;
		first_pg = nfps_pkg::FIRST_PAGE_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_window_settings();
		test_random_traffic();
		repeat (20) @(posedge clk);

		$display("Covered %0d accesses over %0d window settings: %0d ok, %0d rejected, %0d out",
			items_sent, settings_run, status_seen[nfps_pkg::ST_OK],
			status_seen[nfps_pkg::ST_INVALID], status_seen[nfps_pkg::ST_OOB]);
		$display("%0d queries found a blank page, %0d field mismatches", blank_pages_seen,
			err_count);
		if (err_count == 0)
			$display("tb_nor_flash_page_store: PASS");
		else
			$display("tb_nor_flash_page_store: FAIL");
		$finish;
	end

	// Hang guard, far beyond the slowest legal run
	initial begin
		#50ms;
		$display("tb_nor_flash_page_store: FAIL");
		$finish;
	end

endmodule
